@@ rtl/fcc_pkg.sv @@
// Shared types and constants for the cluster chain engine.
// Depends on nothing; imported by fat_cluster_chain_engine.
package fcc_pkg;

  localparam int MAX_CLUSTERS = 4096;
  localparam int ROOT_CLUSTER = 1;
  localparam int TBL_DEPTH    = MAX_CLUSTERS + 1;
  localparam int TBL_AW       = $clog2(TBL_DEPTH);

  localparam logic [15:0]       END_MARK   = 16'hFFFF;
  localparam logic [15:0]       LAST16     = 16'(MAX_CLUSTERS);
  localparam logic [31:0]       LAST32     = 32'(MAX_CLUSTERS);
  localparam logic [TBL_AW-1:0] LAST_IDX   = TBL_AW'(MAX_CLUSTERS);
  localparam logic [TBL_AW-1:0] HINT_RESET = TBL_AW'(ROOT_CLUSTER + 1);
  localparam logic [TBL_AW-1:0] ROOT_IDX   = TBL_AW'(ROOT_CLUSTER);
  localparam logic [31:0]       ROOT32     = 32'(ROOT_CLUSTER);

  typedef enum logic [2:0] {
    ACT_READ   = 3'd0,
    ACT_WRITE  = 3'd1,
    ACT_CREATE = 3'd2,
    ACT_REMOVE = 3'd3,
    ACT_NEXT   = 3'd4,
    ACT_TOSEC  = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BADPREV = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_COUNT = 2'd0,
    REG_FIRST = 2'd1,
    REG_SPC   = 2'd2
  } cfg_reg_t;

  typedef enum logic [13:0] {
    S_CLEAR      = 14'b00000000000001,
    S_IDLE       = 14'b00000000000010,
    S_RD_WAIT    = 14'b00000000000100,
    S_SCAN_ISSUE = 14'b00000000001000,
    S_SCAN_CHECK = 14'b00000000010000,
    S_LINK       = 14'b00000000100000,
    S_MARK       = 14'b00000001000000,
    S_PREV_CHECK = 14'b00000010000000,
    S_FREE_RD    = 14'b00000100000000,
    S_FREE_WR    = 14'b00001000000000,
    S_DIV        = 14'b00010000000000,
    S_NS_DEC     = 14'b00100000000000,
    S_NS_RD      = 14'b01000000000000,
    S_CONV       = 14'b10000000000000
  } state_t;

endpackage

@@ rtl/fat_cluster_chain_engine.sv @@
// Cluster chain engine: link table, free-cluster search and sector arithmetic.
// Depends on fcc_pkg for constants, action codes and the sequencer state type.
// Work per item: a write or unused code finishes straight from idle without raising busy;
// a read waits for the registered table read; create scans from the hint for a free entry,
// then links and marks it; remove frees entries one by one; next sector runs a 32-step divider.
// Throughput: one item at a time; other items hold busy high until their done strobe.
// Reset: synchronous; afterwards a clearing sweep writes all 4097 entries to free
// with busy high. Done strobes cannot be stalled by the receiver.
module fat_cluster_chain_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action,
  input  logic [15:0] cluster,
  input  logic [15:0] second_cluster,
  input  logic [31:0] sector,
  output logic        done,
  output logic [15:0] cluster_out,
  output logic [31:0] sector_out,
  output logic        chain_ended,
  output logic [1:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import fcc_pkg::*;

  // Link table memory, one write and one registered read port.
  logic [15:0] tbl [0:TBL_DEPTH-1];
  logic              mem_we, mem_re;
  logic [TBL_AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]       mem_wdata, rdata;
  logic              rd_ok, rd_ok_next;
  logic [15:0]       rd_val;

  // Configuration registers.
  logic [12:0] cluster_count;
  logic [31:0] data_first_sector;
  logic [3:0]  sectors_in_cluster;

  // Sequencer and working registers.
  state_t            state, state_next;
  logic [2:0]        act;
  logic [15:0]       clst, second;
  logic [31:0]       sec;
  logic [TBL_AW-1:0] hint, cand, clr_cnt;
  logic [15:0]       cur;
  logic [31:0]       dq;
  logic [3:0]        rem;
  logic [4:0]        div_cnt;

  logic        accept;
  logic [3:0]  spc;
  logic [TBL_AW-1:0] limit;
  logic [12:0] count_eff;
  logic [4:0]  trial;
  logic        trial_ge;
  logic [31:0] here;
  logic [31:0] conv_arg, conv_dif, conv_res;
  logic [35:0] conv_prod;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign rd_val    = rd_ok ? rdata : 16'd0;

  // A sectors-per-cluster value of zero behaves as one.
  assign spc = (sectors_in_cluster == 4'd0) ? 4'd1 : sectors_in_cluster;

  // The scan never reads past the last table entry, whatever the count says.
  assign count_eff = (cluster_count > 13'(MAX_CLUSTERS)) ? 13'(MAX_CLUSTERS) : cluster_count;
  assign limit     = ROOT_IDX + TBL_AW'(count_eff);

  // One restoring division step per cycle: shift in the next offset bit and
  // subtract the divisor when it fits. Remainder always stays below spc.
  assign trial    = {rem, dq[31]};
  assign trial_ge = (trial >= {1'b0, spc});
  assign here     = dq + ROOT32;

  // Shared cluster-to-sector converter used by both sector actions.
  assign conv_arg  = (state == S_NS_RD) ? {16'd0, rd_val} : {16'd0, clst};
  assign conv_dif  = conv_arg - ROOT32;
  assign conv_prod = {4'd0, conv_dif} * {32'd0, spc};
  assign conv_res  = data_first_sector + conv_prod[31:0];

  // Memory commands come straight from the sequencer state.
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = 16'd0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    rd_ok_next = rd_ok;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
      end
      S_IDLE: begin
        if (accept) begin
          if (action == ACT_READ) begin
            rd_ok_next = (cluster <= LAST16);
            mem_re     = rd_ok_next;
            mem_raddr  = cluster[TBL_AW-1:0];
          end else if (action == ACT_WRITE) begin
            mem_we    = (cluster <= LAST16);
            mem_waddr = cluster[TBL_AW-1:0];
            mem_wdata = second_cluster;
          end else if (action == ACT_REMOVE && second_cluster != 16'd0) begin
            rd_ok_next = (second_cluster <= LAST16);
            mem_re     = rd_ok_next;
            mem_raddr  = second_cluster[TBL_AW-1:0];
          end
        end
      end
      S_SCAN_ISSUE: begin
        // Below the limit the candidate is always inside the table.
        mem_re     = (cand < limit);
        mem_raddr  = cand;
        rd_ok_next = 1'b1;
      end
      S_LINK: begin
        mem_we    = (clst <= LAST16);
        mem_waddr = clst[TBL_AW-1:0];
        mem_wdata = 16'(cand);
      end
      S_MARK: begin
        mem_we    = 1'b1;
        mem_waddr = cand;
        mem_wdata = END_MARK;
      end
      S_PREV_CHECK: begin
        mem_we    = (rd_val == clst) && (second <= LAST16);
        mem_waddr = second[TBL_AW-1:0];
        mem_wdata = END_MARK;
      end
      S_FREE_RD: begin
        rd_ok_next = (cur <= LAST16);
        mem_re     = (cur != 16'd0) && rd_ok_next;
        mem_raddr  = cur[TBL_AW-1:0];
      end
      S_FREE_WR: begin
        mem_we    = (cur <= LAST16);
        mem_waddr = cur[TBL_AW-1:0];
        mem_wdata = 16'd0;
      end
      S_NS_DEC: begin
        rd_ok_next = (here <= LAST32);
        mem_re     = (rem == spc - 4'd1) && rd_ok_next;
        mem_raddr  = here[TBL_AW-1:0];
      end
      S_RD_WAIT, S_SCAN_CHECK, S_DIV, S_NS_RD, S_CONV: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= tbl[mem_raddr];
    end
  end

  // Configuration writes are taken in any state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_count      <= 13'd4096;
      data_first_sector  <= 32'd0;
      sectors_in_cluster <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_COUNT: cluster_count      <= cfg_data[12:0];
        REG_FIRST: data_first_sector  <= cfg_data;
        REG_SPC:   sectors_in_cluster <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // Next-state selection for the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:      if (clr_cnt == LAST_IDX) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          unique case (action)
            ACT_READ:   state_next = S_RD_WAIT;
            ACT_CREATE: state_next = S_SCAN_ISSUE;
            ACT_REMOVE: state_next = (second_cluster != 16'd0) ? S_PREV_CHECK : S_FREE_RD;
            ACT_NEXT:   state_next = S_DIV;
            ACT_TOSEC:  state_next = S_CONV;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_RD_WAIT:    state_next = S_IDLE;
      S_SCAN_ISSUE: state_next = (cand < limit) ? S_SCAN_CHECK : S_IDLE;
      S_SCAN_CHECK: begin
        if (rdata != 16'd0) begin
          state_next = S_SCAN_ISSUE;
        end else begin
          state_next = (clst != 16'd0) ? S_LINK : S_MARK;
        end
      end
      S_LINK:       state_next = S_MARK;
      S_MARK:       state_next = S_IDLE;
      S_PREV_CHECK: state_next = (rd_val == clst) ? S_FREE_RD : S_IDLE;
      S_FREE_RD:    state_next = (cur == 16'd0) ? S_IDLE : S_FREE_WR;
      S_FREE_WR:    state_next = (rd_val == END_MARK) ? S_IDLE : S_FREE_RD;
      S_DIV:        if (div_cnt == 5'd31) state_next = S_NS_DEC;
      S_NS_DEC:     state_next = (rem == spc - 4'd1) ? S_NS_RD : S_IDLE;
      S_NS_RD:      state_next = S_IDLE;
      S_CONV:       state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      hint    <= HINT_RESET;
      done    <= 1'b0;
      rd_ok   <= 1'b0;
    end else begin
      state <= state_next;
      rd_ok <= rd_ok_next;
      done  <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
        end
        S_IDLE: begin
          if (accept) begin
            act     <= action;
            clst    <= cluster;
            second  <= second_cluster;
            sec     <= sector;
            cand    <= hint;
            cur     <= cluster;
            dq      <= sector - data_first_sector;
            rem     <= 4'd0;
            div_cnt <= 5'd0;
            // Writes and unused codes complete right away with zero fields.
            if (action != ACT_READ && action != ACT_CREATE && action != ACT_REMOVE &&
                action != ACT_NEXT && action != ACT_TOSEC) begin
              done        <= 1'b1;
              cluster_out <= 16'd0;
              sector_out  <= 32'd0;
              chain_ended <= 1'b0;
              status      <= ST_OK;
            end
          end
        end
        S_RD_WAIT: begin
          done        <= 1'b1;
          cluster_out <= rd_val;
          sector_out  <= 32'd0;
          chain_ended <= 1'b0;
          status      <= ST_OK;
        end
        S_SCAN_ISSUE: begin
          if (cand >= limit) begin
            done        <= 1'b1;
            cluster_out <= 16'd0;
            sector_out  <= 32'd0;
            chain_ended <= 1'b0;
            status      <= ST_NOSPACE;
          end
        end
        S_SCAN_CHECK: begin
          if (rdata != 16'd0) begin
            cand <= cand + 1'b1;
          end
        end
        S_LINK: begin
        end
        S_MARK: begin
          hint        <= cand + 1'b1;
          done        <= 1'b1;
          cluster_out <= 16'(cand);
          sector_out  <= 32'd0;
          chain_ended <= 1'b0;
          status      <= ST_OK;
        end
        S_PREV_CHECK: begin
          if (rd_val != clst) begin
            done        <= 1'b1;
            cluster_out <= 16'd0;
            sector_out  <= 32'd0;
            chain_ended <= 1'b0;
            status      <= ST_BADPREV;
          end
        end
        S_FREE_RD: begin
          if (cur == 16'd0) begin
            done        <= 1'b1;
            cluster_out <= 16'd0;
            sector_out  <= 32'd0;
            chain_ended <= 1'b0;
            status      <= ST_OK;
          end
        end
        S_FREE_WR: begin
          // A freed cluster below the hint pulls the hint down to it.
          if (cur < 16'(hint)) begin
            hint <= cur[TBL_AW-1:0];
          end
          if (rd_val == END_MARK) begin
            done        <= 1'b1;
            cluster_out <= 16'd0;
            sector_out  <= 32'd0;
            chain_ended <= 1'b0;
            status      <= ST_OK;
          end else begin
            cur <= rd_val;
          end
        end
        S_DIV: begin
          dq      <= {dq[30:0], trial_ge};
          rem     <= trial_ge ? 4'(trial - {1'b0, spc}) : trial[3:0];
          div_cnt <= div_cnt + 1'b1;
        end
        S_NS_DEC: begin
          // Inside a cluster the next sector simply follows.
          if (rem != spc - 4'd1) begin
            done        <= 1'b1;
            cluster_out <= 16'd0;
            sector_out  <= sec + 32'd1;
            chain_ended <= 1'b0;
            status      <= ST_OK;
          end
        end
        S_NS_RD: begin
          done        <= 1'b1;
          cluster_out <= 16'd0;
          status      <= ST_OK;
          if (rd_val == END_MARK) begin
            sector_out  <= 32'hFFFF_FFFF;
            chain_ended <= 1'b1;
          end else begin
            sector_out  <= conv_res;
            chain_ended <= 1'b0;
          end
        end
        S_CONV: begin
          done        <= 1'b1;
          cluster_out <= 16'd0;
          sector_out  <= conv_res;
          chain_ended <= 1'b0;
          status      <= ST_OK;
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy || done)) else $error("accepted item neither busy nor done");
  a_hint_range: assert property (@(posedge clk) disable iff (rst)
    (hint >= ROOT_IDX) && (hint <= TBL_AW'(MAX_CLUSTERS + 1)))
    else $error("search hint out of range");
  a_port_conflict: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re)) else $error("read and write in one cycle");
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start)) else $error("done without an item");
  a_act_held: assert property (@(posedge clk) disable iff (rst)
    (busy && state != S_CLEAR && $past(busy)) |-> $stable(act))
    else $error("action changed while working");
`endif

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for fat_cluster_chain_engine: a scoreboard class predicts each result.
// Depends on fcc_pkg and the fat_cluster_chain_engine RTL.
module tb;
  import fcc_pkg::*;

  // Action codes that the block does not define; they must produce an all-zero result.
  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;
  localparam int CYCLE_LIMIT = 40000000;
  localparam int PHASES = 6;

  typedef struct {
    logic [15:0] clus;
    logic [31:0] sec;
    logic        ended;
    logic [1:0]  stat;
  } fat_result_t;

  // Shadow of the link table, the search hint and the registers, plus the
  // queue of results that accepted items are still owed.
  class chain_scoreboard;
    logic [15:0] links [0:MAX_CLUSTERS];
    int unsigned hint;
    int unsigned last_alloc;
    logic [12:0] count;
    logic [31:0] first;
    logic [3:0]  spc;
    fat_result_t owed [$];
    int errors;

    function new();
      foreach (links[i]) links[i] = '0;
      hint = ROOT_CLUSTER + 1;
      last_alloc = 0;
      count = 13'd4096;
      first = '0;
      spc = 4'd1;
      errors = 0;
    endfunction

    function logic [15:0] rd(int unsigned idx);
      return (idx > MAX_CLUSTERS) ? 16'h0 : links[idx];
    endfunction

    function void wr(int unsigned idx, logic [15:0] val);
      if (idx <= MAX_CLUSTERS) links[idx] = val;
    endfunction

    function logic [31:0] spc_eff();
      return (spc == 0) ? 32'd1 : 32'(spc);
    endfunction

    function logic [31:0] to_sector(logic [31:0] c);
      return first + (c - ROOT32) * spc_eff();
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_COUNT: count = data[12:0];
        REG_FIRST: first = data;
        REG_SPC:   spc = data[3:0];
        default: ;
      endcase
    endfunction

    function void note_item(logic [2:0] act, logic [15:0] clus, logic [15:0] prev,
                            logic [31:0] sec);
      fat_result_t r;
      int unsigned cnt, lim, cand, cur, nxt;
      logic [31:0] ofs, sp;
      bit found;
      r = '{16'h0, 32'h0, 1'b0, ST_OK};
      case (act)
        ACT_READ:  r.clus = rd(clus);
        ACT_WRITE: wr(clus, prev);
        ACT_CREATE: begin
          cnt = (count > MAX_CLUSTERS) ? MAX_CLUSTERS : count;
          lim = ROOT_CLUSTER + cnt;
          if (lim > MAX_CLUSTERS + 1) lim = MAX_CLUSTERS + 1;
          cand = hint;
          found = 0;
          while (cand < lim) begin
            if (links[cand] == 0) begin
              found = 1;
              break;
            end
            cand++;
          end
          if (found) begin
            if (clus != 0) wr(clus, 16'(cand));
            wr(cand, END_MARK);
            hint = cand + 1;
            last_alloc = cand;
            r.clus = 16'(cand);
          end else begin
            r.stat = ST_NOSPACE;
          end
        end
        ACT_REMOVE: begin
          if (prev != 0 && rd(prev) != clus) begin
            r.stat = ST_BADPREV;
          end else begin
            if (prev != 0) wr(prev, END_MARK);
            cur = clus;
            // Freeing stops at an end mark or at an entry that is already free.
            while (cur != 0) begin
              nxt = rd(cur);
              wr(cur, 16'h0);
              if (cur < hint) hint = cur;
              if (nxt == END_MARK) break;
              cur = nxt;
            end
          end
        end
        ACT_NEXT: begin
          sp = spc_eff();
          ofs = sec - first;
          if (ofs % sp == sp - 1) begin
            nxt = rd(ofs / sp + ROOT32);
            if (nxt == END_MARK) begin
              r.ended = 1'b1;
              r.sec = 32'hFFFF_FFFF;
            end else begin
              r.sec = to_sector(nxt);
            end
          end else begin
            r.sec = sec + 1;
          end
        end
        ACT_TOSEC: r.sec = to_sector(clus);
        default: ;
      endcase
      owed.push_back(r);
    endfunction

    function void check_result(logic [15:0] clus, logic [31:0] sec, logic ended,
                               logic [1:0] stat);
      fat_result_t e;
      if (owed.size() == 0) begin
        $display("%0t: result with nothing owed: cluster_out %h sector_out %h", $time,
                 clus, sec);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (clus !== e.clus) begin
        $display("%0t: cluster_out expected %h actual %h", $time, e.clus, clus);
        errors++;
      end
      if (sec !== e.sec) begin
        $display("%0t: sector_out expected %h actual %h", $time, e.sec, sec);
        errors++;
      end
      if (ended !== e.ended) begin
        $display("%0t: chain_ended expected %b actual %b", $time, e.ended, ended);
        errors++;
      end
      if (stat !== e.stat) begin
        $display("%0t: status expected %0d actual %0d", $time, e.stat, stat);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  action = '0;
  logic [15:0] cluster = '0;
  logic [15:0] second_cluster = '0;
  logic [31:0] sector = '0;
  logic        done;
  logic [15:0] cluster_out;
  logic [31:0] sector_out;
  logic        chain_ended;
  logic [1:0]  status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  chain_scoreboard sb = new();
  int idle_pct = 0;
  int unsigned cycles = 0;

  fat_cluster_chain_engine u_dut (.*);

  always #5 clk = ~clk;

  // An item is taken at the edge where start is high and busy is low; the
  // shadow model is advanced at that same edge, so it always matches the
  // table state that the next item will see.
  always @(posedge clk) begin
    if (!rst && start && !busy) sb.note_item(action, cluster, second_cluster, sector);
    if (!rst && done) sb.check_result(cluster_out, sector_out, chain_ended, status);
  end

  // The run is bounded by a generous cycle budget covering the clearing sweep.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("fat_cluster_chain_engine: mismatch");
      $finish;
    end
  end

  // Inputs change on the falling edge. Start is only lowered when the sender
  // idles, so a held start is never dropped and raised in the same step.
  task automatic send_item(logic [2:0] a, logic [15:0] c, logic [15:0] p, logic [31:0] s);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    action = a;
    cluster = c;
    second_cluster = p;
    sector = s;
    start = 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // Registers are only written once every owed result has arrived and the
  // block has had time to settle.
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk);
    start = 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Picks a cluster in or just past the range in use, which keeps scans and
  // frees short while still hitting the table edges.
  function automatic logic [15:0] pick_cluster();
    int unsigned lim;
    lim = (sb.count > MAX_CLUSTERS) ? MAX_CLUSTERS : sb.count;
    if (lim > 200 && $urandom_range(3) != 0) lim = 200;
    return 16'($urandom_range(lim + 1, 0));
  endfunction

  // Mostly well-formed traffic: chains grow from the last allocation, removes
  // usually name the true predecessor, and next-sector hits cluster ends.
  task automatic random_item();
    int r;
    logic [15:0] c, p;
    logic [31:0] k, sp;
    r = $urandom_range(99);
    if (r < 30) begin
      c = $urandom_range(1) ? 16'h0 : 16'(sb.last_alloc);
      send_item(ACT_CREATE, c, 16'($urandom), $urandom);
    end else if (r < 50) begin
      p = pick_cluster();
      if ($urandom_range(2) != 0) send_item(ACT_REMOVE, sb.rd(p), p, $urandom);
      else send_item(ACT_REMOVE, pick_cluster(), 16'h0, $urandom);
    end else if (r < 62) begin
      send_item(ACT_READ, pick_cluster(), 16'($urandom), $urandom);
    end else if (r < 70) begin
      case ($urandom_range(3))
        0: p = END_MARK;
        1: p = 16'h0;
        2: p = pick_cluster();
        default: p = 16'($urandom);
      endcase
      send_item(ACT_WRITE, pick_cluster(), p, $urandom);
    end else if (r < 82) begin
      sp = sb.spc_eff();
      k = $urandom_range(1) ? sp - 1 : 32'($urandom_range(sp - 1, 0));
      c = pick_cluster();
      send_item(ACT_NEXT, 16'($urandom), 16'($urandom), sb.to_sector(c) + k);
    end else if (r < 90) begin
      send_item(ACT_TOSEC, pick_cluster(), 16'($urandom), $urandom);
    end else begin
      send_item(3'($urandom_range(7)), 16'($urandom), 16'($urandom), $urandom);
    end
  endtask

  initial begin
    logic [31:0] phase_first [PHASES] = '{32'h0, 32'hFFFF_FFF0, 32'h1234_5678,
                                          32'hFFFF_FFFF, 32'h0000_0100, 32'h8000_0000};
    logic [12:0] phase_count [PHASES] = '{13'd64, 13'd8191, 13'd1, 13'd4096, 13'd40,
                                          13'd200};
    logic [3:0]  phase_spc [PHASES] = '{4'd0, 4'd15, 4'd8, 4'd1, 4'd3, 4'd2};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed items at reset settings: table edges, every action and the
    // corner cases, including a looped chain and both undefined action codes.
    idle_pct = 36;
    send_item(ACT_READ, 16'd0, 16'h0, 32'h0);
    send_item(ACT_READ, 16'd4096, 16'h0, 32'h0);
    send_item(ACT_READ, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(ACT_WRITE, 16'd4096, END_MARK, 32'h0);
    send_item(ACT_READ, 16'd4096, 16'h0, 32'h0);
    send_item(ACT_WRITE, 16'hFFFF, 16'h1234, 32'h0);
    send_item(ACT_CREATE, 16'd0, 16'h0, 32'h0);
    send_item(ACT_CREATE, 16'd2, 16'h0, 32'h0);
    send_item(ACT_REMOVE, 16'd3, 16'd5, 32'h0);
    send_item(ACT_NEXT, 16'h0, 16'h0, 32'd2);
    send_item(ACT_NEXT, 16'h0, 16'h0, 32'd1);
    send_item(ACT_NEXT, 16'h0, 16'h0, 32'd9);
    send_item(ACT_REMOVE, 16'd3, 16'd2, 32'h0);
    send_item(ACT_WRITE, 16'd5, 16'd6, 32'h0);
    send_item(ACT_WRITE, 16'd6, 16'd5, 32'h0);
    send_item(ACT_REMOVE, 16'd5, 16'h0, 32'h0);
    send_item(ACT_TOSEC, 16'd0, 16'h0, 32'h0);
    send_item(ACT_TOSEC, 16'hFFFF, 16'h0, 32'h0);
    send_item(ACT_SPARE6, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(ACT_SPARE7, 16'h5555, 16'hAAAA, 32'h5555_AAAA);
    write_reg(REG_COUNT, 32'd1);
    send_item(ACT_CREATE, 16'd0, 16'h0, 32'h0);

    // Random phases across register settings; the sender idles at three rates.
    for (int ph = 0; ph < PHASES; ph++) begin
      idle_pct = (ph < 2) ? 36 : (ph < 4) ? 50 : 0;
      write_reg(REG_COUNT, 32'(phase_count[ph]));
      write_reg(REG_FIRST, (ph == 4) ? $urandom : phase_first[ph]);
      write_reg(REG_SPC, 32'(phase_spc[ph]));
      for (int n = 0; n < 155; n++) random_item();
    end

    @(negedge clk);
    start = 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (sb.errors == 0) begin
      $display("fat_cluster_chain_engine: match");
    end else begin
      $display("fat_cluster_chain_engine: mismatch");
    end
    $finish;
  end
endmodule
